### rtl/mm_pkg.sv
package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W       = 4;
	localparam int IDX_W       = 3;
	localparam int ADDR_MAX_W  = 6;
	localparam int WORD_W      = 32;
	localparam int CMD_DEPTH   = 4;
	localparam int RES_DEPTH   = 4;
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_START  = 2'd2;

	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_LEN = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [1:0]            kind;
		logic [ADDR_MAX_W-1:0] addr;
		logic [WORD_W-1:0]     value;
	} cmd_t;

	typedef struct packed {
		logic              last;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  row;
		logic [WORD_W-1:0] product;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/mm_fifo.sv
module mm_fifo
	import mm_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### rtl/mm_front.sv
module mm_front
	import mm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        req_type,
	input  logic [IDX_W-1:0]  row,
	input  logic [IDX_W-1:0]  col,
	input  logic [WORD_W-1:0] value,
	input  logic              q_full,
	output logic              push,
	output cmd_t              cmd
);

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam logic [AW-1:0] MD_A = AW'(MAX_DIM);
	localparam logic [IDX_W:0] MD_I = (IDX_W + 1)'(MAX_DIM);

	logic          in_range;
	logic          keep;
	logic [AW-1:0] addr;

	assign in_range = ({1'b0, row} < MD_I) && ({1'b0, col} < MD_I);
	assign addr     = AW'(row) * MD_A + AW'(col);

	always_comb begin
		cmd.addr  = ADDR_MAX_W'(addr);
		cmd.value = value;
		unique case (req_type)
			REQ_LOAD_A: begin
				cmd.kind = KIND_LOAD_A;
				keep     = in_range;
			end
			REQ_LOAD_B: begin
				cmd.kind = KIND_LOAD_B;
				keep     = in_range;
			end
			REQ_START: begin
				cmd.kind = KIND_START;
				keep     = 1'b1;
			end
			default: begin
				cmd.kind = KIND_START;
				keep     = 1'b0;
			end
		endcase
	end

	// drop reserved requests and loads outside the store
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full && keep;

endmodule

### rtl/mm_back.sv
module mm_back
	import mm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	input  logic [DIM_W-1:0]     nr,
	input  logic [DIM_W-1:0]     nk,
	input  logic [DIM_W-1:0]     nc,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output res_t                 res,
	output logic [RES_CNT_W-1:0] reserved
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam logic [AW-1:0] MD_A = AW'(MAX_DIM);

	typedef struct packed {
		logic             first;
		logic             kend;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	logic [WORD_W-1:0] a_mem [DEPTH];
	logic [WORD_W-1:0] b_mem [DEPTH];

	logic                 busy_q;
	logic [IW-1:0]        i_q;
	logic [IW-1:0]        j_q;
	logic [IW-1:0]        k_q;
	logic [DIM_W-1:0]     nr_q;
	logic [DIM_W-1:0]     nk_q;
	logic [DIM_W-1:0]     nc_q;
	logic [RES_CNT_W-1:0] reserved_q;

	logic              v_s1;
	tag_t              tag_s1;
	logic [WORD_W-1:0] rd_a_s1;
	logic [WORD_W-1:0] rd_b_s1;
	logic              v_s2;
	tag_t              tag_s2;
	logic [WORD_W-1:0] prod_s2;
	logic [WORD_W-1:0] acc_q;

	logic              k_end;
	logic              j_end;
	logic              i_end;
	logic              issue;
	logic              take;
	logic              push;
	logic [AW-1:0]     a_addr;
	logic [AW-1:0]     b_addr;
	logic [WORD_W-1:0] sum;
	res_t              res_in;
	logic              res_empty;

	assign cmd_pop = cmd_valid && !busy_q;

	assign k_end = (DIM_W'(k_q) + DIM_W'(1) == nk_q);
	assign j_end = (DIM_W'(j_q) + DIM_W'(1) == nc_q);
	assign i_end = (DIM_W'(i_q) + DIM_W'(1) == nr_q);

	// open a new element only when the result queue has room reserved for it
	assign issue = busy_q && ((k_q != '0) || (reserved_q < RES_CNT_W'(RES_DEPTH)));

	assign a_addr = AW'(i_q) * MD_A + AW'(k_q);
	assign b_addr = AW'(k_q) * MD_A + AW'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			nr_q   <= DIM_W'(1);
			nk_q   <= DIM_W'(1);
			nc_q   <= DIM_W'(1);
		end else if (cmd_pop && cmd.kind == KIND_START) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			nr_q   <= nr;
			nk_q   <= nk;
			nc_q   <= nc;
		end else if (issue) begin
			if (!k_end) begin
				k_q <= k_q + IW'(1);
			end else begin
				k_q <= '0;
				if (j_end) begin
					j_q <= '0;
					if (i_end) begin
						busy_q <= 1'b0;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == KIND_LOAD_A) begin
			a_mem[cmd.addr[AW-1:0]] <= cmd.value;
		end
		if (cmd_pop && cmd.kind == KIND_LOAD_B) begin
			b_mem[cmd.addr[AW-1:0]] <= cmd.value;
		end
		rd_a_s1 <= a_mem[a_addr];
		rd_b_s1 <= b_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		tag_s1.first <= (k_q == '0);
		tag_s1.kend  <= k_end;
		tag_s1.last  <= i_end && j_end;
		tag_s1.row   <= IDX_W'(i_q);
		tag_s1.col   <= IDX_W'(j_q);
		tag_s2       <= tag_s1;
		prod_s2      <= rd_a_s1 * rd_b_s1;
		if (v_s2) begin
			acc_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	assign sum  = tag_s2.first ? prod_s2 : acc_q + prod_s2;
	assign push = v_s2 && tag_s2.kend;

	assign res_in.last    = tag_s2.last;
	assign res_in.col     = tag_s2.col;
	assign res_in.row     = tag_s2.row;
	assign res_in.product = sum;

	assign take = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (issue && (k_q == '0) && !take) begin
			reserved_q <= reserved_q + RES_CNT_W'(1);
		end else if (take && !(issue && (k_q == '0))) begin
			reserved_q <= reserved_q - RES_CNT_W'(1);
		end
	end

	mm_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (res_in),
		.full    (),
		.rd_en   (take),
		.rd_data (res),
		.empty   (res_empty)
	);

	assign m_tvalid = !res_empty;
	assign reserved = reserved_q;

endmodule

### rtl/integer_matrix_multiply.sv
// Signed 32-bit matrix multiplier for matrices up to MAX_DIM x MAX_DIM. Load requests
// (tuser 0 for A, 1 for B) write one element and are taken one per clock while the
// command queue has room; requests with tuser 3 or an index not below MAX_DIM are
// dropped. A start request (tuser 2) emits the product in row-major order, tlast on the
// final element. It runs on a single multiply-accumulate unit fed by one read port on
// each store, so one start performs rows_a * cols_b * inner_len multiply-accumulate steps
// one after another through a pipeline; requests behind it wait in a four-entry queue.
// Sums wrap modulo 2^32. Register values of 0 act as 1 and values above MAX_DIM act as
// MAX_DIM. Store entries hold no defined value until loaded.
module integer_matrix_multiply
	import mm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // row[2:0], col[5:3], value[37:6], zero[39:38]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // product[31:0], out_row[34:32], out_col[37:35], zero
	output logic        m_tlast
);

	localparam logic [DIM_W-1:0] MD_D = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]     rows_a_q;
	logic [DIM_W-1:0]     inner_len_q;
	logic [DIM_W-1:0]     cols_b_q;
	logic                 wr_en;
	logic [DIM_W-1:0]     rd_reg;

	logic                 push;
	cmd_t                 cmd_in;
	cmd_t                 cmd_out;
	logic                 q_full;
	logic                 q_empty;
	logic                 cmd_pop;
	res_t                 res;
	logic [RES_CNT_W-1:0] reserved;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(8);
			inner_len_q <= DIM_W'(8);
			cols_b_q    <= DIM_W'(8);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ROWS_A:    rows_a_q    <= pwdata[DIM_W-1:0];
				REG_INNER_LEN: inner_len_q <= pwdata[DIM_W-1:0];
				REG_COLS_B:    cols_b_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_A:    rd_reg = rows_a_q;
			REG_INNER_LEN: rd_reg = inner_len_q;
			REG_COLS_B:    rd_reg = cols_b_q;
			default:       rd_reg = '0;
		endcase
	end

	assign prdata = {(32 - DIM_W)'(0), rd_reg};

	mm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.row      (s_tdata[2:0]),
		.col      (s_tdata[5:3]),
		.value    (s_tdata[37:6]),
		.q_full   (q_full),
		.push     (push),
		.cmd      (cmd_in)
	);

	mm_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (q_empty)
	);

	mm_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.nr        (clamp_dim(rows_a_q, MD_D)),
		.nk        (clamp_dim(inner_len_q, MD_D)),
		.nc        (clamp_dim(cols_b_q, MD_D)),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res),
		.reserved  (reserved)
	);

	assign m_tdata = {2'b00, res.col, res.row, res.product};
	assign m_tlast = res.last;

	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved <= RES_CNT_W'(RES_DEPTH))
		else $error("result reservations exceed queue depth");

	a_result_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> reserved != '0)
		else $error("pending result without reservation");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !q_empty)
		else $error("request popped from empty queue");

endmodule
